// ===== hw/rtl/bmp_pkg.sv =====
package bmp_pkg;

	localparam int unsigned VAL_W = 30;
	localparam int unsigned CNT_W = 16;
	localparam int unsigned MUL_W = 31;
	localparam int unsigned RED_W = 32;
	localparam int unsigned BIT_W = 5;

	localparam logic [VAL_W-1:0] PRIME      = 30'd1000000007;
	localparam logic [VAL_W-1:0] INV_EXP    = 30'd1000000005;
	// floor(2^60 / PRIME)
	localparam logic [MUL_W-1:0] BARRETT_MU = 31'd1152921496;
	localparam logic [BIT_W-1:0] EXP_MSB    = 5'd29;

	localparam int unsigned N_MAX_DEF = 65535;

	typedef logic [VAL_W-1:0] resid_t;
	typedef logic [CNT_W-1:0] count_t;

endpackage

// ===== hw/rtl/bmp_modmul.sv =====
module bmp_modmul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  bmp_pkg::resid_t op_a,
	input  bmp_pkg::resid_t op_b,
	output logic            done,
	output bmp_pkg::resid_t product
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_QUOT = 2'd1;
	localparam logic [1:0] PH_BACK = 2'd2;
	localparam logic [1:0] PH_FIX  = 2'd3;

	localparam logic [bmp_pkg::RED_W-1:0] P1 = bmp_pkg::RED_W'(bmp_pkg::PRIME);
	localparam logic [bmp_pkg::RED_W-1:0] P2 = P1 << 1;

	logic [1:0]                     phase_q;
	logic [2*bmp_pkg::MUL_W-1:0]    prod_q;
	logic [bmp_pkg::RED_W-1:0]      x_q;
	logic [bmp_pkg::MUL_W-1:0]      mul_a;
	logic [bmp_pkg::MUL_W-1:0]      mul_b;
	logic [bmp_pkg::RED_W-1:0]      rem;
	logic [bmp_pkg::RED_W-1:0]      rem_fix;
	logic                           done_q;
	bmp_pkg::resid_t                product_q;

	// one shared multiplier: a*b, then Barrett quotient, then quotient*p
	always_comb begin
		unique case (phase_q)
			PH_QUOT: begin
				mul_a = prod_q[2*bmp_pkg::VAL_W-1:bmp_pkg::VAL_W-1];
				mul_b = bmp_pkg::BARRETT_MU;
			end
			PH_BACK: begin
				mul_a = prod_q[2*bmp_pkg::MUL_W-1:bmp_pkg::MUL_W];
				mul_b = bmp_pkg::MUL_W'(bmp_pkg::PRIME);
			end
			default: begin
				mul_a = bmp_pkg::MUL_W'(op_a);
				mul_b = bmp_pkg::MUL_W'(op_b);
			end
		endcase
	end

	// remainder is below 3p, exact modulo 2^32
	assign rem = x_q - prod_q[bmp_pkg::RED_W-1:0];

	always_comb begin
		priority if (rem >= P2) begin
			rem_fix = rem - P2;
		end else if (rem >= P1) begin
			rem_fix = rem - P1;
		end else begin
			rem_fix = rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_QUOT;
					end
				end
				PH_QUOT: phase_q <= PH_BACK;
				PH_BACK: phase_q <= PH_FIX;
				PH_FIX: begin
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (phase_q == PH_QUOT) begin
			x_q <= prod_q[bmp_pkg::RED_W-1:0];
		end
		if (phase_q == PH_FIX) begin
			product_q <= rem_fix[bmp_pkg::VAL_W-1:0];
		end
	end

	assign done    = done_q;
	assign product = product_q;

endmodule

// ===== hw/rtl/binomial_mod_prime_unit.sv =====
// Sequence: an accepted request uses one shared modular multiplier for m factorial steps,
// m = max(top_count, 1), then one denominator product, 45 Fermat power steps (30 squares,
// 15 multiplies) and one final product. r > n or n > N_MAX: no products are made and
// the result is zero, passed straight to ST_OUT.
// Throughput: one request at a time, the next taken in the cycle the result goes valid.
// Reset clears the sequencer and the result valid flag; no state spans requests.
module binomial_mod_prime_unit #(
	parameter int unsigned N_MAX = bmp_pkg::N_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [bmp_pkg::CNT_W-1:0] top_count,
	input  logic [bmp_pkg::CNT_W-1:0] choose_count,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [bmp_pkg::VAL_W-1:0] binomial_value
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_FACT   = 4'd1;
	localparam logic [3:0] ST_FACT_W = 4'd2;
	localparam logic [3:0] ST_DEN    = 4'd3;
	localparam logic [3:0] ST_DEN_W  = 4'd4;
	localparam logic [3:0] ST_SQR    = 4'd5;
	localparam logic [3:0] ST_SQR_W  = 4'd6;
	localparam logic [3:0] ST_MULB   = 4'd7;
	localparam logic [3:0] ST_MULB_W = 4'd8;
	localparam logic [3:0] ST_FIN    = 4'd9;
	localparam logic [3:0] ST_FIN_W  = 4'd10;
	localparam logic [3:0] ST_OUT    = 4'd11;

	logic [3:0]                  state_q;
	bmp_pkg::count_t             n_q;
	bmp_pkg::count_t             rs_q;
	bmp_pkg::count_t             nrs_q;
	bmp_pkg::count_t             k_q;
	bmp_pkg::resid_t             acc_q;
	bmp_pkg::resid_t             fr_q;
	bmp_pkg::resid_t             fnr_q;
	bmp_pkg::resid_t             base_q;
	bmp_pkg::resid_t             pw_q;
	logic [bmp_pkg::BIT_W-1:0]   bit_q;
	logic                        res_valid_q;
	bmp_pkg::resid_t             binomial_value_q;

	logic                        accept;
	logic                        bad_req;
	bmp_pkg::count_t             diff;
	bmp_pkg::count_t             rs;
	logic                        mm_start;
	bmp_pkg::resid_t             mm_a;
	bmp_pkg::resid_t             mm_b;
	logic                        mm_done;
	bmp_pkg::resid_t             mm_prod;
	logic                        out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign bad_req   = (choose_count > top_count) || (32'(top_count) > N_MAX);
	assign diff      = top_count - choose_count;
	assign rs        = (choose_count > diff) ? diff : choose_count;
	assign out_free  = !res_valid_q || res_ready;

	assign mm_start = (state_q == ST_FACT) || (state_q == ST_DEN) || (state_q == ST_SQR)
		|| (state_q == ST_MULB) || (state_q == ST_FIN);

	always_comb begin
		unique case (state_q)
			ST_FACT: begin
				mm_a = acc_q;
				mm_b = bmp_pkg::resid_t'(k_q);
			end
			ST_DEN: begin
				mm_a = fr_q;
				mm_b = fnr_q;
			end
			ST_SQR: begin
				mm_a = pw_q;
				mm_b = pw_q;
			end
			ST_MULB: begin
				mm_a = pw_q;
				mm_b = base_q;
			end
			default: begin
				mm_a = acc_q;
				mm_b = pw_q;
			end
		endcase
	end

	bmp_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.op_a    (mm_a),
		.op_b    (mm_b),
		.done    (mm_done),
		.product (mm_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= bad_req ? ST_OUT : ST_FACT;
					end
				end
				ST_FACT:   state_q <= ST_FACT_W;
				ST_FACT_W: begin
					if (mm_done) begin
						state_q <= (k_q >= n_q) ? ST_DEN : ST_FACT;
					end
				end
				ST_DEN:    state_q <= ST_DEN_W;
				ST_DEN_W: begin
					if (mm_done) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR:    state_q <= ST_SQR_W;
				ST_SQR_W: begin
					if (mm_done) begin
						priority if (bmp_pkg::INV_EXP[bit_q]) begin
							state_q <= ST_MULB;
						end else if (bit_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SQR;
						end
					end
				end
				ST_MULB:   state_q <= ST_MULB_W;
				ST_MULB_W: begin
					if (mm_done) begin
						state_q <= (bit_q == '0) ? ST_FIN : ST_SQR;
					end
				end
				ST_FIN:    state_q <= ST_FIN_W;
				ST_FIN_W: begin
					if (mm_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					n_q   <= top_count;
					rs_q  <= rs;
					nrs_q <= top_count - rs;
					k_q   <= bmp_pkg::count_t'(1);
					acc_q <= bad_req ? '0 : bmp_pkg::resid_t'(1);
					fr_q  <= bmp_pkg::resid_t'(1);
					fnr_q <= bmp_pkg::resid_t'(1);
				end
			end
			ST_FACT_W: begin
				if (mm_done) begin
					acc_q <= mm_prod;
					if (k_q == rs_q) begin
						fr_q <= mm_prod;
					end
					if (k_q == nrs_q) begin
						fnr_q <= mm_prod;
					end
					if (k_q < n_q) begin
						k_q <= k_q + bmp_pkg::count_t'(1);
					end
				end
			end
			ST_DEN_W: begin
				if (mm_done) begin
					base_q <= mm_prod;
					pw_q   <= bmp_pkg::resid_t'(1);
					bit_q  <= bmp_pkg::EXP_MSB;
				end
			end
			ST_SQR_W: begin
				if (mm_done) begin
					pw_q <= mm_prod;
					if (!bmp_pkg::INV_EXP[bit_q] && bit_q != '0) begin
						bit_q <= bit_q - bmp_pkg::BIT_W'(1);
					end
				end
			end
			ST_MULB_W: begin
				if (mm_done) begin
					pw_q <= mm_prod;
					if (bit_q != '0) begin
						bit_q <= bit_q - bmp_pkg::BIT_W'(1);
					end
				end
			end
			ST_FIN_W: begin
				if (mm_done) begin
					acc_q <= mm_prod;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					binomial_value_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid      = res_valid_q;
	assign binomial_value = binomial_value_q;

endmodule
